// ===== design/waveform_minmax_decimator_macros.svh =====
// Assertion macros for the waveform min/max decimator.
`ifndef WAVEFORM_MINMAX_DECIMATOR_MACROS_SVH
`define WAVEFORM_MINMAX_DECIMATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WMM_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define WMM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define WMM_ASSERT_IMP(label, clk, rst, cond, prop)
`define WMM_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== design/wmm_pkg.sv =====
// Shared constants and controller/datapath interface types of the decimator.
`default_nettype none
package wmm_pkg;
   localparam int FRACTION_BITS = 20;
   localparam int SAMPLE_W      = 24;
   localparam int VALUE_W       = 22;
   localparam int PIXEL_W       = 16;
   localparam int COUNT_W       = 24;
   localparam int BIN_W         = COUNT_W + 1;
   localparam int MAX_FLUSH     = 32;
   localparam int FLUSH_CNT_W   = $clog2(MAX_FLUSH + 1);
   localparam int ONE_INT       = 1 << FRACTION_BITS;

   localparam logic signed [SAMPLE_W-1:0] IN_POS_ONE  = SAMPLE_W'(ONE_INT);
   localparam logic signed [SAMPLE_W-1:0] IN_NEG_ONE  = SAMPLE_W'(-ONE_INT);
   localparam logic signed [VALUE_W-1:0]  VAL_POS_ONE = VALUE_W'(ONE_INT);
   localparam logic signed [VALUE_W-1:0]  VAL_NEG_ONE = VALUE_W'(-ONE_INT);

   localparam logic REG_PIXEL_WIDTH  = 1'b0;
   localparam logic REG_SAMPLE_COUNT = 1'b1;

   typedef struct packed {
      logic take_sample;
      logic emit_flush;
      logic join_sample;
      logic emit_close;
      logic finish_step;
      logic div_start;
      logic start_channel;
   } wmm_cmd_type;

   typedef struct packed {
      logic cfg_wr;
      logic div_done;
      logic flush_ok;
      logic close_ok;
      logic slot_free;
   } wmm_status_type;
endpackage
`default_nettype wire

// ===== design/wmm_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the bin step size.
`default_nettype none
module wmm_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [wmm_pkg::COUNT_W-1:0]  dividend,
   input  wire logic [wmm_pkg::PIXEL_W-1:0]  divisor,
   output logic                              done,
   output logic [wmm_pkg::COUNT_W-1:0]       quotient,
   output logic [wmm_pkg::PIXEL_W-1:0]       remainder
);
   import wmm_pkg::*;

   localparam int CNT_W = $clog2(COUNT_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [COUNT_W-1:0]   quo_ff, quo_in;
   logic [PIXEL_W-1:0]   rem_ff, rem_in;
   logic [PIXEL_W-1:0]   div_ff, div_in;
   logic [PIXEL_W:0]     trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[COUNT_W-1]};
      fits    = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[COUNT_W-2:0], fits};
         rem_in = fits ? PIXEL_W'(trial - {1'b0, div_ff}) : trial[PIXEL_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(COUNT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ===== design/wmm_datapath.sv =====
// Datapath of the decimator: registers, bin edge tracking, min/max and result word.
`default_nettype none
module wmm_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire wmm_pkg::wmm_cmd_type          cmd,
   output wmm_pkg::wmm_status_type            status,
   input  wire logic [wmm_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [63:0]                        rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [2:0]                    csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata
);
   import wmm_pkg::*;

   logic [PIXEL_W-1:0]        width_ff, width_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        step_q_ff, step_q_in;
   logic [PIXEL_W-1:0]        step_r_ff, step_r_in;
   logic [PIXEL_W-1:0]        pixel_ff, pixel_in;
   logic [BIN_W-1:0]          bin_q_ff, bin_q_in;
   logic [PIXEL_W-1:0]        bin_r_ff, bin_r_in;
   logic [COUNT_W-1:0]        seen_ff, seen_in;
   logic signed [VALUE_W-1:0] rmin_ff, rmin_in;
   logic signed [VALUE_W-1:0] rmax_ff, rmax_in;
   logic signed [VALUE_W-1:0] samp_ff, samp_in;
   logic                      rvalid_ff, rvalid_in;
   logic [PIXEL_W-1:0]        rpix_ff, rpix_in;
   logic [VALUE_W-1:0]        rmin_out_ff, rmin_out_in;
   logic [VALUE_W-1:0]        rmax_out_ff, rmax_out_in;
   logic                      rlast_ff, rlast_in;
   logic                      rdone_ff, rdone_in;

   logic [PIXEL_W-1:0]        w_eff;
   logic [COUNT_W-1:0]        n_eff;
   logic                      cfg_wr;
   logic                      div_done;
   logic [COUNT_W-1:0]        div_q;
   logic [PIXEL_W-1:0]        div_r;
   logic [PIXEL_W:0]          r_sum;
   logic                      wrap;
   logic [PIXEL_W-1:0]        bin_r_next;
   logic [BIN_W-1:0]          bin_q_next;
   logic [PIXEL_W:0]          pixel_p1;
   logic [BIN_W-1:0]          seen_p1;
   logic                      pixel_open;
   logic                      more_after;
   logic                      emit;
   logic signed [SAMPLE_W-1:0] s_in;

   assign w_eff  = (width_ff == '0) ? PIXEL_W'(1) : width_ff;
   assign n_eff  = (count_ff == '0) ? COUNT_W'(1) : count_ff;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   wmm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (n_eff),
      .divisor   (w_eff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      r_sum      = {1'b0, bin_r_ff} + {1'b0, step_r_ff};
      wrap       = r_sum >= {1'b0, w_eff};
      bin_r_next = wrap ? PIXEL_W'(r_sum - {1'b0, w_eff}) : r_sum[PIXEL_W-1:0];
      bin_q_next = bin_q_ff + {1'b0, step_q_ff} + BIN_W'(wrap);
      pixel_p1   = {1'b0, pixel_ff} + (PIXEL_W+1)'(1);
      seen_p1    = {1'b0, seen_ff} + BIN_W'(1);
      pixel_open = pixel_ff < w_eff;
      more_after = (pixel_p1 < {1'b0, w_eff}) && (bin_q_next <= seen_p1);
      emit       = cmd.emit_flush || cmd.emit_close;
      s_in       = $signed(req_sample);
   end

   assign status.cfg_wr    = cfg_wr;
   assign status.div_done  = div_done;
   assign status.flush_ok  = pixel_open && (bin_q_ff <= {1'b0, seen_ff});
   assign status.close_ok  = pixel_open && (bin_q_ff <= seen_p1);
   assign status.slot_free = !rvalid_ff || rsp_tready;

   always_comb begin
      width_in    = width_ff;
      count_in    = count_ff;
      step_q_in   = step_q_ff;
      step_r_in   = step_r_ff;
      pixel_in    = pixel_ff;
      bin_q_in    = bin_q_ff;
      bin_r_in    = bin_r_ff;
      seen_in     = seen_ff;
      rmin_in     = rmin_ff;
      rmax_in     = rmax_ff;
      samp_in     = samp_ff;
      rvalid_in   = rvalid_ff && !rsp_tready;
      rpix_in     = rpix_ff;
      rmin_out_in = rmin_out_ff;
      rmax_out_in = rmax_out_ff;
      rlast_in    = rlast_ff;
      rdone_in    = rdone_ff;

      if (cfg_wr) begin
         case (csr_paddr[2])
            REG_PIXEL_WIDTH:  width_in = csr_pwdata[PIXEL_W-1:0];
            REG_SAMPLE_COUNT: count_in = csr_pwdata[COUNT_W-1:0];
            default:          width_in = width_ff;
         endcase
      end

      if (cmd.take_sample) begin
         if (s_in > IN_POS_ONE) begin
            samp_in = VAL_POS_ONE;
         end else if (s_in < IN_NEG_ONE) begin
            samp_in = VAL_NEG_ONE;
         end else begin
            samp_in = s_in[VALUE_W-1:0];
         end
      end

      if (cmd.join_sample) begin
         if (samp_ff < rmin_ff) begin
            rmin_in = samp_ff;
         end
         if (samp_ff > rmax_ff) begin
            rmax_in = samp_ff;
         end
      end

      if (emit) begin
         rvalid_in   = 1'b1;
         rpix_in     = pixel_ff;
         rmin_out_in = rmin_ff;
         rmax_out_in = rmax_ff;
         rlast_in    = cmd.emit_close || !more_after;
         rdone_in    = pixel_p1 == {1'b0, w_eff};
         rmin_in     = VAL_POS_ONE;
         rmax_in     = VAL_NEG_ONE;
         pixel_in    = pixel_p1[PIXEL_W-1:0];
         bin_q_in    = bin_q_next;
         bin_r_in    = bin_r_next;
      end

      if (cmd.finish_step) begin
         seen_in = seen_p1[COUNT_W-1:0];
      end

      if (cmd.div_start || (cmd.finish_step && seen_p1 >= {1'b0, n_eff})) begin
         pixel_in = '0;
         seen_in  = '0;
         bin_q_in = {1'b0, step_q_ff};
         bin_r_in = step_r_ff;
         rmin_in  = VAL_POS_ONE;
         rmax_in  = VAL_NEG_ONE;
      end

      if (cmd.start_channel) begin
         step_q_in = div_q;
         step_r_in = div_r;
         pixel_in  = '0;
         seen_in   = '0;
         bin_q_in  = {1'b0, div_q};
         bin_r_in  = div_r;
         rmin_in   = VAL_POS_ONE;
         rmax_in   = VAL_NEG_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= PIXEL_W'(1);
         count_ff  <= COUNT_W'(1);
         step_q_ff <= COUNT_W'(1);
         step_r_ff <= '0;
         pixel_ff  <= '0;
         bin_q_ff  <= BIN_W'(1);
         bin_r_ff  <= '0;
         seen_ff   <= '0;
         rmin_ff   <= VAL_POS_ONE;
         rmax_ff   <= VAL_NEG_ONE;
         rvalid_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         count_ff  <= count_in;
         step_q_ff <= step_q_in;
         step_r_ff <= step_r_in;
         pixel_ff  <= pixel_in;
         bin_q_ff  <= bin_q_in;
         bin_r_ff  <= bin_r_in;
         seen_ff   <= seen_in;
         rmin_ff   <= rmin_in;
         rmax_ff   <= rmax_in;
         rvalid_ff <= rvalid_in;
      end
      samp_ff     <= samp_in;
      rpix_ff     <= rpix_in;
      rmin_out_ff <= rmin_out_in;
      rmax_out_ff <= rmax_out_in;
      rlast_ff    <= rlast_in;
      rdone_ff    <= rdone_in;
   end

   always_comb begin
      case (csr_paddr[2])
         REG_PIXEL_WIDTH:  csr_prdata = {16'd0, width_ff};
         REG_SAMPLE_COUNT: csr_prdata = {8'd0, count_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {4'd0, rmax_out_ff, rmin_out_ff, rpix_ff};
   assign rsp_tlast  = rlast_ff;
   assign rsp_tuser  = rdone_ff;
endmodule
`default_nettype wire

// ===== design/wmm_controller.sv =====
// Controller state machine that sequences sample steps and the step-size division.
`default_nettype none
module wmm_controller (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire wmm_pkg::wmm_status_type  status,
   output wmm_pkg::wmm_cmd_type          cmd
);
   import wmm_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PREP   = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_FLUSH  = 3'd3;
   localparam logic [2:0] ST_CLOSE  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [FLUSH_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ready = !status.cfg_wr;
            if (req_tvalid && ready) begin
               cmd.take_sample = 1'b1;
               cnt_in          = '0;
               state_in        = ST_FLUSH;
            end
         end
         ST_PREP: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.start_channel = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.flush_ok && (cnt_ff < FLUSH_CNT_W'(MAX_FLUSH))) begin
               if (status.slot_free) begin
                  cmd.emit_flush = 1'b1;
                  cnt_in         = cnt_ff + FLUSH_CNT_W'(1);
               end
            end else begin
               cmd.join_sample = 1'b1;
               state_in        = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (!status.close_ok) begin
               cmd.finish_step = 1'b1;
               state_in        = ST_IDLE;
            end else if (status.slot_free) begin
               cmd.emit_close  = 1'b1;
               cmd.finish_step = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (status.cfg_wr) begin
         state_in = ST_PREP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_tready = ready;
endmodule
`default_nettype wire

// ===== design/waveform_minmax_decimator.sv =====
// Top level of the waveform min/max decimator: controller, datapath and checks.
//
// The req channel takes one audio sample word per handshake (signed Q3.20 in
// req_tdata). Each sample is clamped to +-1.0 and folded into the running
// min/max of the current pixel bin. The rsp channel delivers one word per
// reported bin: pixel index, min and max in rsp_tdata, rsp_tlast on the last
// word caused by a sample, rsp_tuser on the final bin of the channel.
// A sample runs through the controller states IDLE, FLUSH and CLOSE: FLUSH walks
// the empty bins it reports (up to 32), one word per cycle while the output
// register is free, and CLOSE sends the closing bin's word to end the step,
// all through a single output register. A waiting result word does not block
// acceptance of the next sample. When the receiver stalls, the controller
// holds in its current step until the output register is free again.
// The csr port holds pixel_width at address 0 and sample_count at address 4;
// a write restarts the channel and runs the division of the bin size (states
// PREP and DIVIDE), during which req_tready is low.
// Reset restores pixel_width = sample_count = 1 with a fresh channel at once.
`default_nettype none
`include "waveform_minmax_decimator_macros.svh"
module waveform_minmax_decimator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [23:0] sample
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [15:0] pixel_index, [37:16] min_value, [59:38] max_value
   output logic             rsp_tlast,
   output logic             rsp_tuser,   // [0] channel_done
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import wmm_pkg::*;

   wmm_cmd_type    cmd;
   wmm_status_type status;
   logic           min_ok;

   wmm_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wmm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

   assign csr_pready = 1'b1;

   assign min_ok = ($signed(rsp_tdata[37:16]) <= VAL_POS_ONE) &&
                   ($signed(rsp_tdata[37:16]) >= VAL_NEG_ONE);

   `WMM_ASSERT_IMP(a_done_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   `WMM_ASSERT_IMP(a_emit_needs_slot, clock, reset, cmd.emit_flush || cmd.emit_close, status.slot_free)
   `WMM_ASSERT_NEXT(a_cfg_blocks_input, clock, reset, status.cfg_wr, !req_tready)
   `WMM_ASSERT_IMP(a_min_in_range, clock, reset, rsp_tvalid, min_ok)
endmodule
`default_nettype wire

// ===== dv/tb_waveform_minmax_decimator.sv =====
// Self-checking testbench for the waveform min/max decimator.
`timescale 1ns / 1ps
module tb_waveform_minmax_decimator;
   import wmm_pkg::*;

   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 45;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 4000;
   localparam int TARGET_ITEMS  = 410;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;

   typedef struct packed {
      logic [15:0]        pixel;
      logic signed [21:0] lo;
      logic signed [21:0] hi;
      logic               last;
      logic               done;
   } pixel_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // [23:0] sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [15:0] pixel_index, [37:16] min_value, [59:38] max_value
   logic        rsp_tlast;
   logic        rsp_tuser;         // [0] channel_done
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   waveform_minmax_decimator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   logic [23:0]     sample_queue[$];
   pixel_word_type  expected_words[$];
   int unsigned     samples_pushed = 0;
   int unsigned     samples_taken = 0;
   int unsigned     fail_count = 0;

   bit              no_idle = 1'b0;
   stall_mode_type  stall_mode = STALL_NONE;
   int unsigned     holds_wanted = 0;

   // Mirror of the block's registers and bin tracking state.
   int unsigned        cfg_width = 1;
   int unsigned        cfg_count = 1;
   int unsigned        bin_pixel;
   int unsigned        end_quot;
   int unsigned        end_rem;
   int unsigned        seen;
   logic signed [21:0] lo_val;
   logic signed [21:0] hi_val;

   function automatic int unsigned width_eff();
      return (cfg_width == 0) ? 1 : cfg_width;
   endfunction

   function automatic int unsigned count_eff();
      return (cfg_count == 0) ? 1 : cfg_count;
   endfunction

   task automatic restart_channel();
      bin_pixel = 0;
      seen      = 0;
      end_quot  = count_eff() / width_eff();
      end_rem   = count_eff() % width_eff();
      lo_val    = VAL_POS_ONE;
      hi_val    = VAL_NEG_ONE;
   endtask

   task automatic close_bin();
      pixel_word_type w;
      w.pixel = bin_pixel[15:0];
      w.lo    = lo_val;
      w.hi    = hi_val;
      w.last  = 1'b0;
      w.done  = (bin_pixel + 1 == width_eff());
      expected_words.push_back(w);
      lo_val   = VAL_POS_ONE;
      hi_val   = VAL_NEG_ONE;
      end_quot = end_quot + count_eff() / width_eff();
      end_rem  = end_rem + count_eff() % width_eff();
      if (end_rem >= width_eff()) begin
         end_rem  = end_rem - width_eff();
         end_quot = end_quot + 1;
      end
      bin_pixel = bin_pixel + 1;
   endtask

   task automatic predict_sample(input logic [23:0] raw);
      logic signed [23:0] s;
      logic signed [21:0] v;
      int                 n;
      pixel_word_type     w;
      s = raw;
      n = 0;
      // Empty bins that ended before this sample, at most MAX_FLUSH per sample word.
      while (n < MAX_FLUSH && bin_pixel < width_eff() && end_quot <= seen) begin
         close_bin();
         n++;
      end
      if (s > IN_POS_ONE) begin
         v = VAL_POS_ONE;
      end else if (s < IN_NEG_ONE) begin
         v = VAL_NEG_ONE;
      end else begin
         v = s[21:0];
      end
      if (v < lo_val) lo_val = v;
      if (v > hi_val) hi_val = v;
      if (bin_pixel < width_eff() && end_quot <= seen + 1) begin
         close_bin();
         n++;
      end
      if (n > 0) begin
         w = expected_words.pop_back();
         w.last = 1'b1;
         expected_words.push_back(w);
      end
      seen = seen + 1;
      if (seen >= count_eff()) restart_channel();
   endtask

   task automatic report_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Sender: bursts of random length separated by random gaps, unless no_idle is set.
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (!no_idle && gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_tdata  <= sample_queue.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 15);
               gap_left   = $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: its own stall pattern, plus long hold-offs on request.
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned stall_phase = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_wanted) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            STALL_NONE: begin
               rsp_tready <= 1'b1;
            end
            STALL_RANDOM: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
               stall_phase = (stall_phase + 1) % 7;
               rsp_tready <= (stall_phase >= 3);
            end
         endcase
      end
   end

   // Monitor: predicts on every accepted sample word, checks every result word.
   always @(posedge clock) begin
      pixel_word_type w;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result word, expected none, actual %h", $time,
                        rsp_tdata);
            end else begin
               w = expected_words.pop_front();
               report_field("pixel_index", 32'(rsp_tdata[15:0]), 32'(w.pixel));
               report_field("min_value", 32'(rsp_tdata[37:16]), 32'(unsigned'(w.lo)));
               report_field("max_value", 32'(rsp_tdata[59:38]), 32'(unsigned'(w.hi)));
               report_field("last_of_run", 32'(rsp_tlast), 32'(w.last));
               report_field("channel_done", 32'(rsp_tuser), 32'(w.done));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_sample(req_tdata);
            samples_taken++;
         end
      end
   end

   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      while (samples_taken != samples_pushed || expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_PIXEL_WIDTH) begin
         cfg_width = value[15:0];
      end else begin
         cfg_count = value[23:0];
      end
      restart_channel();
   endtask

   task automatic set_geometry(input int unsigned width, input int unsigned count);
      wait_idle();
      write_register(REG_PIXEL_WIDTH, width);
      write_register(REG_SAMPLE_COUNT, count);
      no_idle    = ($urandom_range(0, 3) == 0);
      stall_mode = stall_mode_type'($urandom_range(0, 2));
   endtask

   task automatic offer(input logic [23:0] value);
      sample_queue.push_back(value);
      samples_pushed++;
   endtask

   function automatic logic [23:0] random_sample();
      logic [23:0] r;
      case ($urandom_range(0, 9))
         0, 1: begin
            r = 24'($urandom);
         end
         2: begin
            case ($urandom_range(0, 5))
               0: r = IN_POS_ONE;
               1: r = IN_NEG_ONE;
               2: r = 24'h7FFFFF;
               3: r = 24'h800000;
               4: r = 24'(IN_POS_ONE + 1);
               default: r = 24'(IN_NEG_ONE - 1);
            endcase
         end
         default: begin
            r = 24'($urandom_range(0, 2 * ONE_INT) - ONE_INT);
         end
      endcase
      return r;
   endfunction

   task automatic offer_random(input int unsigned count);
      repeat (count) offer(random_sample());
   endtask

   initial begin
      int unsigned n;
      int unsigned w;
      int unsigned items;

      restart_channel();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // After reset every sample closes the only bin; sample extremes and clamping.
      offer(24'h7FFFFF);
      offer(24'h800000);
      offer(IN_POS_ONE);
      offer(IN_NEG_ONE);
      offer(24'(IN_POS_ONE + 1));
      offer(24'(IN_NEG_ONE - 1));
      offer(24'h000000);
      offer(24'h000001);

      // Zero registers act as one.
      set_geometry(0, 0);
      offer(24'hFFFFFF);
      offer(24'h0F0000);

      // More bins than samples, so empty bins are reported ahead of the closing one.
      set_geometry(5, 3);
      offer(24'h012345);
      offer(24'hF80000);
      offer(24'h100000);

      // Too many bins: the flush limit applies and unreported bins are dropped.
      set_geometry(100, 2);
      offer_random(4);

      // Largest burst of result words per sample.
      set_geometry(65535, 1);
      offer_random(2);

      // Largest register values; no bin closes within these samples.
      set_geometry(65535, 16777215);
      offer_random(3);

      // Receiver holds off for a long stretch while the sender keeps offering.
      set_geometry(8, 8);
      no_idle    = 1'b1;
      stall_mode = STALL_NONE;
      holds_wanted++;
      offer_random(20);
      wait_idle();
      offer_random(20);

      while (samples_pushed < TARGET_ITEMS) begin
         case ($urandom_range(0, 19))
            0:                n = 0;
            1, 2, 3:          n = $urandom_range(25, 300);
            4:                n = $urandom_range(1, 16777215);
            default:          n = $urandom_range(1, 24);
         endcase
         case ($urandom_range(0, 19))
            0: begin
               w = 0;
            end
            1, 2, 3: begin
               // Beyond the supported bin ratio.
               w = (n == 0) ? 40 : 32 * n + $urandom_range(1, 8 * n + 40);
            end
            4, 5, 6, 7: begin
               w = (n == 0) ? 1 : n + $urandom_range(1, 31 * n);
            end
            default: begin
               w = $urandom_range(1, (n == 0) ? 1 : n);
            end
         endcase
         if (w > 65535) w = 65535;
         set_geometry(w, n);
         items = $urandom_range(8, 40);
         if (items > TARGET_ITEMS - samples_pushed) items = TARGET_ITEMS - samples_pushed;
         offer_random(items);
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+design
design/wmm_pkg.sv
design/wmm_divider.sv
design/wmm_datapath.sv
design/wmm_controller.sv
design/waveform_minmax_decimator.sv
dv/tb_waveform_minmax_decimator.sv
